// ===== hdl/mids_pkg.sv =====
`default_nettype none

package mids_pkg;

  // array depth and field widths
  localparam int MAX_LEN_DEFAULT = 1024;
  localparam int VALUE_W         = 31;
  localparam int DIST_W          = 10;

  // one array element
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } mids_in_t;

  // one search result
  typedef struct packed {
    logic [DIST_W-1:0] max_distance;
    logic              overflowed;
  } mids_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic back_init;
    logic back_run;
    logic merge_init;
    logic merge_cmp;
  } mids_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic back_done;
    logic merge_done;
  } mids_sts_t;

endpackage

`default_nettype wire

// ===== hdl/max_index_distance_scan_unit.sv =====
// channel   ports                      handshake
// -------   ------------------------   --------------------------------------
// input     item (value, last)         taken at a clock edge with start & !busy
// result    result (max_distance,      valid for one cycle while done is high,
//           overflowed)                no back-pressure
//
// elements are loaded while busy is low; the item with last set starts a search
// the search is a backward suffix-maximum pass through the element store, then a
// two-pointer merge of up to 2n-1 steps, each a read state (registered store
// reads) and a compare state; busy is high from the final item until the result
// strobe; no clearing pass
// synchronous reset returns the controller to idle and empties the array

`default_nettype none

module max_index_distance_scan_unit
  import mids_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire mids_in_t item,
  output logic          busy,
  output logic          done,
  output mids_out_t     result
);

  mids_cmd_t cmd;
  mids_sts_t sts;

  // search sequencer
  mids_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (item.last),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // stores, pointers and result register
  mids_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== hdl/mids_ram.sv =====
`default_nettype none

module mids_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/mids_ctrl.sv =====
`default_nettype none

module mids_ctrl
  import mids_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      last,
  input  wire mids_sts_t sts,
  output mids_cmd_t      cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BACK,
    ST_MRD,
    ST_MCMP
  } state_t;

  state_t state;

  // commands decoded from the state and the inputs
  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && start;
    cmd.back_init  = cmd.load && last;
    cmd.back_run   = (state == ST_BACK);
    cmd.merge_init = cmd.back_run && sts.back_done;
    cmd.merge_cmp  = (state == ST_MCMP);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start && last) begin
            state <= ST_BACK;
            busy  <= 1'b1;
          end
        end
        ST_BACK: begin
          if (sts.back_done) begin
            state <= ST_MRD;
          end
        end
        ST_MRD: begin
          state <= ST_MCMP;
        end
        ST_MCMP: begin
          if (sts.merge_done) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            state <= ST_MRD;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // busy tracks the search states
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE))
    else $error("busy does not match search state");

  // a result only ends a search
  a_done_after_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(state) == ST_MCMP)
    else $error("result strobe without a finished merge");

  // the result strobe comes with the controller back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE) && !busy)
    else $error("result strobe while still searching");
`endif

endmodule

`default_nettype wire

// ===== hdl/mids_dpath.sv =====
`default_nettype none

module mids_dpath
  import mids_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire mids_in_t  item,
  input  wire mids_cmd_t cmd,
  output mids_sts_t      sts,
  output mids_out_t      result
);

  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int PTR_W  = IDX_W + 1;
  localparam int BEST_W = (PTR_W > DIST_W) ? PTR_W : DIST_W;

  logic [PTR_W-1:0]   count;
  logic [VALUE_W-1:0] running_min;
  logic               ovf;
  logic [IDX_W-1:0]   bk_addr;
  logic [IDX_W-1:0]   bk_wr_addr;
  logic               bk_more;
  logic               bk_pend;
  logic [VALUE_W-1:0] run_max;
  logic [PTR_W-1:0]   lptr;
  logic [PTR_W-1:0]   rptr;
  logic [BEST_W-1:0]  best;

  logic               room;
  logic [VALUE_W-1:0] new_min;
  logic [PTR_W-1:0]   last_idx;
  logic [VALUE_W-1:0] elem_q;
  logic [VALUE_W-1:0] pmin_q;
  logic [VALUE_W-1:0] smax_q;
  logic [VALUE_W-1:0] bk_max;
  logic               take_right;
  logic [PTR_W-1:0]   gap;
  logic               better;
  logic [BEST_W-1:0]  best_next;
  logic [PTR_W-1:0]   lptr_next;
  logic [PTR_W-1:0]   rptr_next;
  logic               finish;

  // load side: prefix minimum and index of the final held element
  assign room     = count < PTR_W'(MAX_LEN);
  assign new_min  = (item.value < running_min) ? item.value : running_min;
  assign last_idx = room ? count : count - PTR_W'(1);

  // backward pass: running suffix maximum
  assign bk_max = (elem_q > run_max) ? elem_q : run_max;

  // merge step on the registered store reads
  assign take_right = pmin_q <= smax_q;
  assign gap        = rptr - lptr;
  assign better     = take_right && (rptr >= lptr) && (BEST_W'(gap) > best);
  assign best_next  = better ? BEST_W'(gap) : best;
  assign lptr_next  = take_right ? lptr : lptr + PTR_W'(1);
  assign rptr_next  = take_right ? rptr + PTR_W'(1) : rptr;

  assign sts.back_done  = bk_pend && !bk_more;
  assign sts.merge_done = (lptr_next >= count) || (rptr_next >= count);
  assign finish         = cmd.merge_cmp && sts.merge_done;

  // element, prefix minimum and suffix maximum stores
  mids_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LEN)
  ) u_elem_ram (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (count[IDX_W-1:0]),
    .wdata (item.value),
    .raddr (bk_addr),
    .rdata (elem_q)
  );

  mids_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LEN)
  ) u_pmin_ram (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (count[IDX_W-1:0]),
    .wdata (new_min),
    .raddr (lptr[IDX_W-1:0]),
    .rdata (pmin_q)
  );

  mids_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LEN)
  ) u_smax_ram (
    .clk   (clk),
    .we    (cmd.back_run && bk_pend),
    .waddr (bk_wr_addr),
    .wdata (bk_max),
    .raddr (rptr[IDX_W-1:0]),
    .rdata (smax_q)
  );

  // array load and per-array flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_min <= '1;
      ovf         <= 1'b0;
    end else if (finish) begin
      count       <= '0;
      running_min <= '1;
      ovf         <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count       <= count + PTR_W'(1);
        running_min <= new_min;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // backward pass sequencing, one read issued per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      bk_more <= 1'b0;
      bk_pend <= 1'b0;
    end else if (cmd.back_init) begin
      bk_addr <= last_idx[IDX_W-1:0];
      bk_more <= 1'b1;
      bk_pend <= 1'b0;
      run_max <= '0;
    end else if (cmd.back_run) begin
      bk_pend <= bk_more;
      if (bk_more) begin
        bk_wr_addr <= bk_addr;
        if (bk_addr == '0) begin
          bk_more <= 1'b0;
        end else begin
          bk_addr <= bk_addr - IDX_W'(1);
        end
      end
      if (bk_pend) begin
        run_max <= bk_max;
      end
    end
  end

  // two-pointer merge
  always_ff @(posedge clk) begin
    if (rst) begin
      lptr <= '0;
      rptr <= '0;
      best <= '0;
    end else if (cmd.merge_init) begin
      lptr <= '0;
      rptr <= '0;
      best <= '0;
    end else if (cmd.merge_cmp) begin
      lptr <= lptr_next;
      rptr <= rptr_next;
      best <= best_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish) begin
      result.max_distance <= best_next[DIST_W-1:0];
      result.overflowed   <= ovf;
    end
  end

`ifndef NO_ASSERTIONS
  // the element count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= PTR_W'(MAX_LEN))
    else $error("element count beyond depth");

  // the left pointer stays at most one past the right pointer
  a_ptr_order: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_cmp |-> ({1'b0, lptr} <= {1'b0, rptr} + (PTR_W + 1)'(1)))
    else $error("left pointer ran past right pointer");

  // the best distance stays below the element count
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_cmp |-> (best < BEST_W'(count)))
    else $error("best distance out of range");
`endif

endmodule

`default_nettype wire

// ===== sim/max_index_distance_scan_unit_tb.sv =====
module max_index_distance_scan_unit_tb;
  import mids_pkg::*;

  localparam int DEPTH       = MAX_LEN_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN_ERRS  = 10;

  // value drawing schemes for random arrays
  typedef enum int {
    VAL_ANY,
    VAL_TINY,
    VAL_NEAR_TOP,
    VAL_MID
  } value_mode_t;

  // tracks the array being loaded and the distances still owed by the block
  class index_distance_board;
    logic [VALUE_W-1:0] elems     [DEPTH];
    logic [VALUE_W-1:0] prefix_lo [DEPTH];
    logic [VALUE_W-1:0] suffix_hi [DEPTH];
    int unsigned        held;
    logic [VALUE_W-1:0] run_min;
    logic               dropped;
    mids_out_t          owed_q [$];
    int unsigned        mismatches;

    function new();
      held       = 0;
      run_min    = '1;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    // largest j - i over the held elements with a[i] <= a[j]
    function int unsigned widest_span();
      int k;
      int unsigned lp, rp, best;
      lp   = 0;
      rp   = 0;
      best = 0;
      if (held == 0) return 0;
      suffix_hi[held-1] = elems[held-1];
      for (k = int'(held) - 2; k >= 0; k--) begin
        suffix_hi[k] = (elems[k] > suffix_hi[k+1]) ? elems[k] : suffix_hi[k+1];
      end
      // merge prefix minima against suffix maxima
      while (lp < held && rp < held) begin
        if (prefix_lo[lp] <= suffix_hi[rp]) begin
          if (rp >= lp && rp - lp > best) best = rp - lp;
          rp++;
        end else begin
          lp++;
        end
      end
      return best;
    endfunction

    // an element was taken by the block
    function void note_element(mids_in_t it);
      mids_out_t   owed;
      int unsigned span;
      if (held < DEPTH) begin
        if (it.value < run_min) run_min = it.value;
        elems[held]     = it.value;
        prefix_lo[held] = run_min;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (it.last) begin
        span              = widest_span();
        owed.max_distance = span[DIST_W-1:0];
        owed.overflowed   = dropped;
        owed_q.push_back(owed);
        held    = 0;
        run_min = '1;
        dropped = 1'b0;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= SHOWN_ERRS) $display("error: %s", msg);
    endfunction

    // a result strobe was seen
    function void check_result(mids_out_t got);
      mids_out_t owed;
      if (owed_q.size() == 0) begin
        flag($sformatf("unexpected result max_distance=%0d overflowed=%0b",
                       got.max_distance, got.overflowed));
      end else begin
        owed = owed_q.pop_front();
        if (got.max_distance !== owed.max_distance)
          flag($sformatf("max_distance expected %0d got %0d",
                         owed.max_distance, got.max_distance));
        if (got.overflowed !== owed.overflowed)
          flag($sformatf("overflowed expected %0b got %0b",
                         owed.overflowed, got.overflowed));
      end
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  mids_in_t  item;
  logic      busy;
  logic      done;
  mids_out_t result;

  index_distance_board board;
  int unsigned         idle_pct;
  int unsigned         cycles;

  max_index_distance_scan_unit uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result strobe monitor
  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1) board.check_result(result);
  end

  function automatic logic [VALUE_W-1:0] pick_value(value_mode_t mode);
    logic [VALUE_W-1:0] v;
    case (mode)
      VAL_TINY:     v = VALUE_W'($urandom_range(0, 15));
      VAL_NEAR_TOP: v = '1 - VALUE_W'($urandom_range(0, 7));
      VAL_MID:      v = VALUE_W'($urandom_range(0, 1000));
      default:      v = VALUE_W'($urandom);
    endcase
    return v;
  endfunction

  // hold start until the item is taken, then maybe go quiet for a while
  task automatic send_element(logic [VALUE_W-1:0] v, logic lst);
    mids_in_t it;
    it.value = v;
    it.last  = lst;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    board.note_element(it);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_list(logic [VALUE_W-1:0] vals [$]);
    int k;
    for (k = 0; k < vals.size(); k++) send_element(vals[k], k == vals.size() - 1);
  endtask

  task automatic send_array(int unsigned len, value_mode_t mode);
    int unsigned k;
    for (k = 0; k < len; k++) send_element(pick_value(mode), k == len - 1);
  endtask

  initial begin
    logic [VALUE_W-1:0] vals [$];
    int unsigned        rand_sent;
    int unsigned        len;
    int                 ph;
    board     = new();
    cycles    = 0;
    idle_pct  = 0;
    rand_sent = 0;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // single elements at the field extremes, zero included
    vals = '{31'd1};
    send_list(vals);
    vals = '{31'h7FFF_FFFF};
    send_list(vals);
    vals = '{31'd0};
    send_list(vals);
    // strictly falling: no pair beyond distance zero
    vals = '{31'd5, 31'd4, 31'd3, 31'd2, 31'd1};
    send_list(vals);
    // rising
    vals = '{31'd1, 31'd2, 31'd3};
    send_list(vals);
    // equal values count as a pair
    vals = '{31'd7, 31'd7};
    send_list(vals);
    vals = '{31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF};
    send_list(vals);
    vals = '{31'd3, 31'd1, 31'd2};
    send_list(vals);
    vals = '{31'h2AAA_AAAA, 31'h5555_5555, 31'd0};
    send_list(vals);

    // random arrays in several idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       idle_pct = 55;
        3:       idle_pct = 37;
        default: idle_pct = 0;
      endcase
      // let the block drain completely before going on
      if (ph == 2) begin
        start <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
      end
      // a completely full array
      if (ph == 1) send_array(DEPTH, VAL_TINY);
      // too many elements: the tail values are dropped, but the last mark still ends the array
      if (ph == 3) send_array(DEPTH + 3, VAL_MID);
      while (rand_sent < (ph + 1) * 113) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_array(len, value_mode_t'($urandom_range(0, 3)));
        rand_sent += len;
      end
    end

    // drain and settle
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mids_pkg.sv
hdl/mids_ram.sv
hdl/mids_ctrl.sv
hdl/mids_dpath.sv
hdl/max_index_distance_scan_unit.sv
sim/max_index_distance_scan_unit_tb.sv
